// ===== rtl/core/pulse_channel_frame_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// pulse channel frame sequencer assertion macros
// concurrent assertion helpers clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef PULSE_CHANNEL_FRAME_SEQUENCER_MACROS_SVH
`define PULSE_CHANNEL_FRAME_SEQUENCER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PCFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PCFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCFS_ASSERT_IMPL(lbl, ante, cons, msg)
`define PCFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/pcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfs_pkg
// shared types, constants and the duty table of the pulse channel sequencer
// ----------------------------------------------------------------------------
package pcfs_pkg;

  // tick divider and frame counter
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned FRAME_W = 14;
  localparam logic [PHASE_W-1:0] TICK_DIVIDE  = 3'd6;
  localparam logic [FRAME_W-1:0] FRAME_LENGTH = 14'd14916;
  localparam logic [FRAME_W-1:0] STEP_QUARTER_A = 14'd3729;
  localparam logic [FRAME_W-1:0] STEP_HALF_A    = 14'd7457;
  localparam logic [FRAME_W-1:0] STEP_QUARTER_B = 14'd11186;

  // pulse channel
  localparam int unsigned TIMER_W  = 12;
  localparam int unsigned RELOAD_W = 11;
  localparam int unsigned DUTY_W   = 8;

  // register addresses
  localparam logic [15:0] ADDR_DUTY      = 16'h4000;
  localparam logic [15:0] ADDR_TIMER_LO  = 16'h4002;
  localparam logic [15:0] ADDR_TIMER_HI  = 16'h4003;
  localparam logic [15:0] ADDR_STATUS    = 16'h4015;

  // duty select codes
  localparam logic [1:0] DUTY_SEL_12 = 2'd0;
  localparam logic [1:0] DUTY_SEL_25 = 2'd1;
  localparam logic [1:0] DUTY_SEL_50 = 2'd2;
  localparam logic [1:0] DUTY_SEL_75 = 2'd3;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e_t;

  typedef struct packed {
    logic        command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic pulse_level;
    logic sample_strobe;
    logic quarter_frame;
    logic half_frame;
  } out_word_t;

  // flags of one tick from the frame counter
  typedef struct packed {
    logic active;
    logic quarter;
    logic half;
  } frame_flags_t;

  // duty waveform for a select code
  function automatic logic [DUTY_W-1:0] duty_lookup(input logic [1:0] sel);
    logic [DUTY_W-1:0] pat;
    unique case (sel)
      DUTY_SEL_12: pat = 8'h01;
      DUTY_SEL_25: pat = 8'h03;
      DUTY_SEL_50: pat = 8'h0F;
      DUTY_SEL_75: pat = 8'hFC;
      default:     pat = 8'h01;
    endcase
    return pat;
  endfunction

endpackage

// ===== rtl/core/pcfs_frame.sv =====
// ----------------------------------------------------------------------------
// pcfs_frame
// tick divider and 4-step frame counter with quarter and half frame flags
// ----------------------------------------------------------------------------
`include "pulse_channel_frame_sequencer_macros.svh"

module pcfs_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick_en,
  output pcfs_pkg::frame_flags_t flags
);
  import pcfs_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [FRAME_W-1:0] frame_pos_r, frame_pos_nxt;
  logic [FRAME_W-1:0] frame_inc;

  // next phase and frame position
  always_comb begin
    phase_nxt     = phase_r;
    frame_pos_nxt = frame_pos_r;
    frame_inc     = frame_pos_r + 1'b1;
    flags         = '0;
    if (tick_en) begin
      if (phase_r == TICK_DIVIDE - 1'b1) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
      if (phase_r == '0) begin
        flags.active  = 1'b1;
        frame_pos_nxt = frame_inc;
        if (frame_inc == STEP_QUARTER_A || frame_inc == STEP_QUARTER_B) begin
          flags.quarter = 1'b1;
        end
        if (frame_inc == STEP_HALF_A) begin
          flags.quarter = 1'b1;
          flags.half    = 1'b1;
        end
        if (frame_inc == FRAME_LENGTH) begin
          flags.quarter = 1'b1;
          flags.half    = 1'b1;
          frame_pos_nxt = '0;
        end
      end
    end
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      frame_pos_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      frame_pos_r <= frame_pos_nxt;
    end
  end

  `PCFS_ASSERT_IMPL(a_frame_in_range, 1'b1, frame_pos_r < FRAME_LENGTH,
    "frame position out of range")
  `PCFS_ASSERT_IMPL(a_phase_in_range, 1'b1, phase_r < TICK_DIVIDE,
    "tick phase out of range")
  `PCFS_ASSERT_IMPL(a_half_is_quarter, flags.half, flags.quarter && flags.active,
    "half frame without quarter frame")

endmodule

// ===== rtl/core/pcfs_pulse.sv =====
// ----------------------------------------------------------------------------
// pcfs_pulse
// pulse channel registers, period timer and rotating duty sequencer
// ----------------------------------------------------------------------------
`include "pulse_channel_frame_sequencer_macros.svh"

module pcfs_pulse (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [15:0] wr_addr,
  input  logic [7:0]  wr_data,
  input  logic        seq_clk_en,
  output logic        level_nxt
);
  import pcfs_pkg::*;

  logic [TIMER_W-1:0]  period_timer_r, period_timer_nxt;
  logic [RELOAD_W-1:0] period_reload_r, period_reload_nxt;
  logic [DUTY_W-1:0]   duty_pattern_r, duty_pattern_nxt;
  logic                level_r;
  logic                channel_enable_r, channel_enable_nxt;

  // register writes and sequencer clocking
  always_comb begin
    period_timer_nxt   = period_timer_r;
    period_reload_nxt  = period_reload_r;
    duty_pattern_nxt   = duty_pattern_r;
    level_nxt          = level_r;
    channel_enable_nxt = channel_enable_r;
    if (wr_en) begin
      priority if (wr_addr == ADDR_DUTY) begin
        duty_pattern_nxt = duty_lookup(wr_data[7:6]);
      end else if (wr_addr == ADDR_TIMER_LO) begin
        period_reload_nxt = {period_reload_r[RELOAD_W-1:8], wr_data};
      end else if (wr_addr == ADDR_TIMER_HI) begin
        period_reload_nxt = {wr_data[2:0], period_reload_r[7:0]};
        period_timer_nxt  = {1'b0, wr_data[2:0], period_reload_r[7:0]};
      end else if (wr_addr == ADDR_STATUS) begin
        channel_enable_nxt = wr_data[0];
      end else begin
        channel_enable_nxt = channel_enable_r;
      end
    end else if (seq_clk_en && channel_enable_r) begin
      if (period_timer_r == '0) begin
        period_timer_nxt = {1'b0, period_reload_r} + 1'b1;
        duty_pattern_nxt = {duty_pattern_r[0], duty_pattern_r[DUTY_W-1:1]};
        level_nxt        = duty_pattern_r[1];
      end else begin
        period_timer_nxt = period_timer_r - 1'b1;
      end
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_timer_r   <= '0;
      period_reload_r  <= '0;
      duty_pattern_r   <= '0;
      level_r          <= 1'b0;
      channel_enable_r <= 1'b0;
    end else begin
      period_timer_r   <= period_timer_nxt;
      period_reload_r  <= period_reload_nxt;
      duty_pattern_r   <= duty_pattern_nxt;
      level_r          <= level_nxt;
      channel_enable_r <= channel_enable_nxt;
    end
  end

  `PCFS_ASSERT_IMPL(a_timer_bound, period_timer_r[TIMER_W-1],
    period_timer_r[TIMER_W-2:0] == '0, "period timer above reload plus one")
  `PCFS_ASSERT_NEXT(a_disabled_holds, !channel_enable_r && !wr_en,
    $stable(period_timer_r) && $stable(duty_pattern_r) && $stable(level_r),
    "disabled channel changed its sequencer")

endmodule

// ===== rtl/core/pcfs_out_buf.sv =====
// ----------------------------------------------------------------------------
// pcfs_out_buf
// result register with a skid stage so a stalled output does not block input
// ----------------------------------------------------------------------------
`include "pulse_channel_frame_sequencer_macros.svh"

module pcfs_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcfs_pkg::out_word_t push_word,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output pcfs_pkg::out_word_t out_data
);
  import pcfs_pkg::*;

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t main_word_r, main_word_nxt;
  out_word_t skid_word_r, skid_word_nxt;
  logic      pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_word_r;

  // buffer steering
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_word_nxt  = main_word_r;
    skid_word_nxt  = skid_word_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_word_nxt  = skid_word_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        main_word_nxt = push_word;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_word_nxt  = push_word;
        skid_valid_nxt = 1'b1;
      end else begin
        main_word_nxt  = push_word;
        main_valid_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    main_word_r <= main_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  `PCFS_ASSERT_IMPL(a_skid_behind_main, skid_valid_r, main_valid_r,
    "skid word held without a main word")
  `PCFS_ASSERT_IMPL(a_no_push_when_full, push, !skid_valid_r,
    "word pushed into a full buffer")
  `PCFS_ASSERT_NEXT(a_skid_drains, pop && skid_valid_r,
    main_valid_r && !skid_valid_r, "skid word not moved forward")

endmodule

// ===== rtl/core/pulse_channel_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// pulse_channel_frame_sequencer
// pulse channel with duty sequencer and 4-step frame counter
// ----------------------------------------------------------------------------
// Each input word is a bus write (command 0) or one clock tick (command 1).
// Every input word yields exactly one result word: the current pulse level
// and the sample strobe, quarter frame and half frame flags of that tick.
// Input channel: in_valid / in_stall / in_data, accepted when valid and not
// stalled. Result channel: out_valid / out_stall / out_data, same rules.
// Each result is registered before it is presented. Throughput: one word per
// cycle while in_stall is low; the state update is a single registered step,
// so back-to-back words see each other's effects with no bubbles.
// A result register plus a one-word skid stage sit on the output: while the
// receiver stalls, one more input word is still taken, then in_stall rises
// (it comes straight from a register) until the receiver drains the skid.
// Reset (rst_n low, synchronous) clears the divider, frame counter, timer,
// reload, duty pattern, level and enable, and empties the output buffer.
// ----------------------------------------------------------------------------
module pulse_channel_frame_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcfs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcfs_pkg::out_word_t out_data
);
  import pcfs_pkg::*;

  logic         accept;
  logic         buf_full;
  logic         is_tick;
  logic         level_nxt;
  frame_flags_t flags;
  out_word_t    result;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;
  assign is_tick  = (in_data.command == CMD_TICK);

  // frame counter
  pcfs_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (accept && is_tick),
    .flags   (flags)
  );

  // pulse channel
  pcfs_pulse u_pulse (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (accept && !is_tick),
    .wr_addr    (in_data.address),
    .wr_data    (in_data.write_data),
    .seq_clk_en (flags.active),
    .level_nxt  (level_nxt)
  );

  // result word
  always_comb begin
    result.pulse_level   = level_nxt;
    result.sample_strobe = flags.active;
    result.quarter_frame = flags.quarter;
    result.half_frame    = flags.half;
  end

  // output buffer
  pcfs_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_word (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
